// ===== rtl/u8sv_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator/decoder.
// Holds the byte classifier used by the front stage and decoded by the back stage.
// No dependencies.
package u8sv_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CP_BITS         = 21;
  localparam int unsigned WIDTH_BITS      = 3;
  localparam int unsigned ERR_OFS_BITS    = 32;

  typedef enum logic [2:0] {
    BC_ASCII,     // 00..7F
    BC_LEAD2,     // C2..DF
    BC_LEAD3,     // E0..EF
    BC_LEAD4,     // F0..F4
    BC_CONT_LO,   // 80..8F
    BC_CONT_MID,  // 90..9F
    BC_CONT_HI,   // A0..BF
    BC_INVALID    // C0, C1, F5..FF
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_e cls;
    logic        last;
  } byte_info_t;

  localparam int unsigned BYTE_INFO_BITS = $bits(byte_info_t);

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    case (b) inside
      [8'h00:8'h7F]: c = BC_ASCII;
      [8'h80:8'h8F]: c = BC_CONT_LO;
      [8'h90:8'h9F]: c = BC_CONT_MID;
      [8'hA0:8'hBF]: c = BC_CONT_HI;
      [8'hC2:8'hDF]: c = BC_LEAD2;
      [8'hE0:8'hEF]: c = BC_LEAD3;
      [8'hF0:8'hF4]: c = BC_LEAD4;
      default:       c = BC_INVALID;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/u8sv_front.sv =====
// Front stage: accepts input bytes, classifies them and tags each with its buffer offset.
// Pushes classified bytes into the queue. Depends on u8sv_pkg.
module u8sv_front #(
  parameter int unsigned OFFSET_BITS = u8sv_pkg::OFFSET_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output u8sv_pkg::byte_info_t      push_info_o,
  output logic [OFFSET_BITS-1:0]    push_offset_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_info_o.data = data_byte_i;
    push_info_o.cls  = u8sv_pkg::classify(data_byte_i);
    push_info_o.last = last_byte_i;
    push_offset_o    = pos_q;
  end

  // Offset wraps; restart at zero after the final byte of a buffer.
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (last_byte_i) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/u8sv_queue.sv =====
// Short FIFO between the front and back stages of the UTF-8 decoder.
// Generic width and depth; no package dependencies.
module u8sv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [WIDTH-1:0] head_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/u8sv_back.sv =====
// Back stage: runs the strict UTF-8 sequence checker on classified bytes and
// drives the registered result channel. Depends on u8sv_pkg.
module u8sv_back #(
  parameter int unsigned OFFSET_BITS = u8sv_pkg::OFFSET_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  u8sv_pkg::byte_info_t                head_info_i,
  input  logic [OFFSET_BITS-1:0]              head_offset_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                has_code_point_o,
  output logic [u8sv_pkg::CP_BITS-1:0]        code_point_o,
  output logic [u8sv_pkg::WIDTH_BITS-1:0]     width_o,
  output logic                                failed_o,
  output logic [u8sv_pkg::ERR_OFS_BITS-1:0]   error_offset_o,
  output logic                                at_end_o
);

  localparam int unsigned CPW = u8sv_pkg::CP_BITS;
  localparam int unsigned WW  = u8sv_pkg::WIDTH_BITS;
  localparam int unsigned EOW = u8sv_pkg::ERR_OFS_BITS;

  // Decode state
  logic [1:0]             pend_q, pend_d;
  logic [CPW-1:0]         partial_q, partial_d;
  logic [WW-1:0]          len_q, len_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   failed_q, failed_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic                   has_q, has_d;
  logic [CPW-1:0]         cp_q, cp_d;
  logic [WW-1:0]          w_q, w_d;
  logic                   fail_out_q, fail_out_d;
  logic [EOW-1:0]         eofs_q, eofs_d;
  logic                   end_q, end_d;

  logic                   take;
  logic                   has, fail, emit, ok, second;
  logic [CPW-1:0]         cp;
  logic [WW-1:0]          w;
  u8sv_pkg::byte_class_e  cls;
  logic [7:0]             data;
  logic                   last;

  assign cls  = head_info_i.cls;
  assign data = head_info_i.data;
  assign last = head_info_i.last;

  // Advance the queue whenever the result register is free or being drained.
  assign take  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  always_comb begin
    pend_d    = pend_q;
    partial_d = partial_q;
    len_d     = len_q;
    start_d   = start_q;
    failed_d  = failed_q;
    has       = 1'b0;
    fail      = 1'b0;
    emit      = 1'b0;
    ok        = 1'b0;
    second    = 1'b0;
    cp        = '0;
    w         = '0;
    if (take) begin
      if (!failed_q) begin
        if (pend_q == 2'd0) begin
          start_d = head_offset_i;
          case (cls)
            u8sv_pkg::BC_ASCII: begin
              has = 1'b1;
              cp  = CPW'(data);
              w   = WW'(1);
            end
            u8sv_pkg::BC_LEAD2: begin
              partial_d = CPW'(data[4:0]);
              len_d     = WW'(2);
              pend_d    = 2'd1;
            end
            u8sv_pkg::BC_LEAD3: begin
              partial_d = CPW'(data[3:0]);
              len_d     = WW'(3);
              pend_d    = 2'd2;
            end
            u8sv_pkg::BC_LEAD4: begin
              partial_d = CPW'(data[2:0]);
              len_d     = WW'(4);
              pend_d    = 2'd3;
            end
            default: begin
              fail = 1'b1;
            end
          endcase
        end else begin
          ok = (cls == u8sv_pkg::BC_CONT_LO) || (cls == u8sv_pkg::BC_CONT_MID) ||
               (cls == u8sv_pkg::BC_CONT_HI);
          second = ((WW'(pend_q) + WW'(1)) == len_q);
          // Tighten the second byte range to reject overlongs, surrogates and > 0x10FFFF.
          if (ok && second) begin
            if (len_q == WW'(3) && partial_q == CPW'(4'h0)) begin
              ok = (cls == u8sv_pkg::BC_CONT_HI);
            end else if (len_q == WW'(3) && partial_q == CPW'(4'hD)) begin
              ok = (cls != u8sv_pkg::BC_CONT_HI);
            end else if (len_q == WW'(4) && partial_q == CPW'(4'h0)) begin
              ok = (cls != u8sv_pkg::BC_CONT_LO);
            end else if (len_q == WW'(4) && partial_q == CPW'(4'h4)) begin
              ok = (cls == u8sv_pkg::BC_CONT_LO);
            end
          end
          if (!ok) begin
            fail = 1'b1;
          end else begin
            partial_d = {partial_q[CPW-7:0], data[5:0]};
            pend_d    = pend_q - 2'd1;
            if (pend_d == 2'd0) begin
              has       = 1'b1;
              cp        = partial_d;
              w         = len_q;
              partial_d = '0;
              len_d     = '0;
            end
          end
        end
        // A sequence still open at the final byte is truncated.
        if (!fail && last && pend_d != 2'd0) begin
          fail = 1'b1;
        end
        if (fail) begin
          failed_d  = 1'b1;
          pend_d    = '0;
          partial_d = '0;
          len_d     = '0;
        end
        emit = has || fail || last;
      end else begin
        emit = last;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    has_d       = has_q;
    cp_d        = cp_q;
    w_d         = w_q;
    fail_out_d  = fail_out_q;
    eofs_d      = eofs_q;
    end_d       = end_q;
    if (take && emit) begin
      out_valid_d = 1'b1;
      has_d       = has;
      cp_d        = cp;
      w_d         = w;
      fail_out_d  = failed_d;
      eofs_d      = failed_d ? EOW'(start_d) : '0;
      end_d       = last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      partial_q   <= '0;
      len_q       <= '0;
      start_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      // Clear everything after the final byte of a buffer.
      if (take && last) begin
        pend_q    <= '0;
        partial_q <= '0;
        len_q     <= '0;
        start_q   <= '0;
        failed_q  <= 1'b0;
      end else begin
        pend_q    <= pend_d;
        partial_q <= partial_d;
        len_q     <= len_d;
        start_q   <= start_d;
        failed_q  <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    has_q      <= has_d;
    cp_q       <= cp_d;
    w_q        <= w_d;
    fail_out_q <= fail_out_d;
    eofs_q     <= eofs_d;
    end_q      <= end_d;
  end

  assign out_valid_o      = out_valid_q;
  assign has_code_point_o = has_q;
  assign code_point_o     = cp_q;
  assign width_o          = w_q;
  assign failed_o         = fail_out_q;
  assign error_offset_o   = eofs_q;
  assign at_end_o         = end_q;

endmodule

// ===== rtl/utf8_stream_validator_decoder.sv =====
// Top level of the strict UTF-8 stream validator/decoder.
// Instantiates u8sv_front, u8sv_queue and u8sv_back; depends on u8sv_pkg.
//
// Feed one buffer as a byte stream with last_byte_i on its final byte. The block
// takes one byte per clock while in_stall_o is low and gives a result for each
// completed code point, for the first failure (bad lead, bad or missing
// continuation, overlong, surrogate, above U+10FFFF, or truncation at the end),
// and always a closing result with at_end_o set on the final byte; error_offset_o
// is the offset of the failing sequence's first byte. After a failure, bytes up to
// the final one produce no result. A byte is classified as it is accepted, waits
// in a QUEUE_DEPTH-entry queue and is decoded into the result register, from which
// its result is presented; with nothing stalled, the one-byte-per-cycle rate is
// kept because the decode state takes a byte each time one leaves the queue.
// Each side stalls independently; the queue absorbs the difference.
module utf8_stream_validator_decoder #(
  parameter int unsigned OFFSET_BITS = u8sv_pkg::OFFSET_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = u8sv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                has_code_point_o,
  output logic [u8sv_pkg::CP_BITS-1:0]        code_point_o,
  output logic [u8sv_pkg::WIDTH_BITS-1:0]     width_o,
  output logic                                failed_o,
  output logic [u8sv_pkg::ERR_OFS_BITS-1:0]   error_offset_o,
  output logic                                at_end_o
);

  localparam int unsigned ENTRY_BITS = u8sv_pkg::BYTE_INFO_BITS + OFFSET_BITS;

  logic                   q_full;
  logic                   push;
  u8sv_pkg::byte_info_t   push_info;
  logic [OFFSET_BITS-1:0] push_offset;
  logic                   pop;
  logic                   head_valid;
  logic [ENTRY_BITS-1:0]  head_data;
  u8sv_pkg::byte_info_t   head_info;
  logic [OFFSET_BITS-1:0] head_offset;

  u8sv_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_info_o  (push_info),
    .push_offset_o(push_offset)
  );

  u8sv_queue #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_info, push_offset}),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_data_o (head_data)
  );

  assign head_info   = u8sv_pkg::byte_info_t'(head_data[ENTRY_BITS-1:OFFSET_BITS]);
  assign head_offset = head_data[OFFSET_BITS-1:0];

  u8sv_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_info_i     (head_info),
    .head_offset_i   (head_offset),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .has_code_point_o(has_code_point_o),
    .code_point_o    (code_point_o),
    .width_o         (width_o),
    .failed_o        (failed_o),
    .error_offset_o  (error_offset_o),
    .at_end_o        (at_end_o)
  );

endmodule
